FILE: hw/rtl/sbus_frame_decoder_top_defines.svh
// Assertion macros used by the frame decoder sequencer.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef SBUS_FRAME_DECODER_TOP_DEFINES_SVH
`define SBUS_FRAME_DECODER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SFD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfd same-cycle check failed");
`define SFD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfd next-cycle check failed");
`else
`define SFD_ASSERT_IMP(lbl, ante, cons)
`define SFD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/sfd_pkg.sv
package sfd_pkg;

	localparam int NUM_CH    = 16;
	localparam int CH_BITS   = 11;
	localparam int CH_IDX_W  = $clog2(NUM_CH);
	localparam int SH_W      = $clog2(CH_BITS);
	localparam int POS_W     = 5;
	localparam int BYTE_W    = 8;
	localparam int BIT_CNT_W = $clog2(BYTE_W);

	localparam logic [BYTE_W-1:0] START_BYTE = 8'h0F;
	localparam logic [BYTE_W-1:0] END_BYTE   = 8'h00;
	localparam logic [POS_W-1:0]  HUNT_POS   = 5'd0;
	localparam logic [POS_W-1:0]  FIRST_POS  = 5'd1;
	localparam logic [POS_W-1:0]  FLAGS_POS  = 5'd23;
	localparam logic [POS_W-1:0]  END_POS    = 5'd24;
	localparam logic [SH_W-1:0]   SH_LAST    = SH_W'(CH_BITS - 1);
	localparam int FS_BIT   = 4;
	localparam int LOST_BIT = 5;

	// One bit write into the accumulator bank, or a clear of the whole bank.
	typedef struct packed {
		logic                clear;
		logic                wr;
		logic [CH_IDX_W-1:0] ch;
		logic [SH_W-1:0]     sh;
		logic                bit_val;
	} acc_cmd_t;

	typedef struct packed {
		logic [CH_IDX_W-1:0] idx;
		logic [CH_BITS-1:0]  value;
		logic                failsafe;
		logic                link_lost;
		logic                last;
	} emit_t;

endpackage

FILE: hw/rtl/sfd_acc.sv
module sfd_acc (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sfd_pkg::acc_cmd_t              cmd,
	input  logic [sfd_pkg::CH_IDX_W-1:0]   rd_ch,
	output logic [sfd_pkg::CH_BITS-1:0]    rd_data
);
	import sfd_pkg::*;

	logic [CH_BITS-1:0] acc_q [NUM_CH];
	logic [CH_BITS-1:0] set_mask;

	assign set_mask = CH_BITS'(cmd.bit_val) << cmd.sh;
	assign rd_data  = acc_q[rd_ch];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				acc_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			for (int i = 0; i < NUM_CH; i++) begin
				acc_q[i] <= '0;
			end
		end else if (cmd.wr) begin
			acc_q[cmd.ch] <= acc_q[cmd.ch] | set_mask;
		end
	end

endmodule

FILE: hw/rtl/sfd_seq.sv
`include "sbus_frame_decoder_top_defines.svh"

module sfd_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sfd_pkg::BYTE_W-1:0]    rx_byte,
	input  logic                          rx_valid,
	output logic                          rx_ready,
	output sfd_pkg::acc_cmd_t             acc_cmd,
	output logic [sfd_pkg::CH_IDX_W-1:0]  rd_ch,
	input  logic [sfd_pkg::CH_BITS-1:0]   rd_data,
	output logic                          emit_valid,
	output sfd_pkg::emit_t                emit,
	input  logic                          emit_ready
);
	import sfd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_UNPACK = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	state_t                state_q;
	logic [POS_W-1:0]      pos_q;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic [CH_IDX_W-1:0]   ch_q;
	logic [SH_W-1:0]       sh_q;
	logic [CH_IDX_W-1:0]   emit_idx_q;
	logic                  fs_q;
	logic                  lost_q;
	logic [BYTE_W-1:0]     shift_q;

	logic rx_acc;
	logic hunting;
	logic is_start;
	logic emit_last;

	assign rx_ready  = (state_q == ST_IDLE);
	assign rx_acc    = rx_valid && rx_ready;
	assign hunting   = (pos_q == HUNT_POS) || (pos_q > END_POS);
	assign is_start  = (rx_byte == START_BYTE);
	assign emit_last = (emit_idx_q == CH_IDX_W'(NUM_CH - 1));

	// The bit inserter walks the frame's stream bits in order, so the
	// channel and bit offset counters replace the divide by eleven.
	always_comb begin
		acc_cmd.clear   = rx_acc && hunting && is_start;
		acc_cmd.wr      = (state_q == ST_UNPACK);
		acc_cmd.ch      = ch_q;
		acc_cmd.sh      = sh_q;
		acc_cmd.bit_val = shift_q[0];
	end

	assign rd_ch = emit_idx_q;

	always_comb begin
		emit_valid     = (state_q == ST_EMIT);
		emit.idx       = emit_idx_q;
		emit.value     = rd_data;
		emit.failsafe  = fs_q;
		emit.link_lost = lost_q;
		emit.last      = emit_last;
	end

	always_ff @(posedge clk) begin
		if (rx_acc) begin
			shift_q <= rx_byte;
		end else if (state_q == ST_UNPACK) begin
			shift_q <= shift_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= HUNT_POS;
			bit_cnt_q  <= '0;
			ch_q       <= '0;
			sh_q       <= '0;
			emit_idx_q <= '0;
			fs_q       <= 1'b0;
			lost_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (rx_acc) begin
						priority if (hunting) begin
							pos_q <= is_start ? FIRST_POS : HUNT_POS;
							if (is_start) begin
								ch_q <= '0;
								sh_q <= '0;
							end
						end else if (pos_q == END_POS) begin
							pos_q <= HUNT_POS;
							if (rx_byte == END_BYTE) begin
								state_q    <= ST_EMIT;
								emit_idx_q <= '0;
							end
						end else if (pos_q == FLAGS_POS) begin
							fs_q   <= rx_byte[FS_BIT];
							lost_q <= rx_byte[LOST_BIT];
							pos_q  <= END_POS;
						end else begin
							pos_q     <= pos_q + FIRST_POS;
							bit_cnt_q <= '0;
							state_q   <= ST_UNPACK;
						end
					end
				end
				ST_UNPACK: begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (sh_q == SH_LAST) begin
						sh_q <= '0;
						ch_q <= ch_q + 1'b1;
					end else begin
						sh_q <= sh_q + 1'b1;
					end
					if (bit_cnt_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_ready) begin
						emit_idx_q <= emit_idx_q + 1'b1;
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SFD_ASSERT_NXT(a_unpack_done, (state_q == ST_UNPACK) && (bit_cnt_q == '1), state_q == ST_IDLE)
	`SFD_ASSERT_NXT(a_good_end, rx_acc && !hunting && (pos_q == END_POS) && (rx_byte == END_BYTE), emit_valid && (emit_idx_q == '0))
	`SFD_ASSERT_NXT(a_emit_hold, emit_valid && !emit_ready, emit_valid && $stable(emit_idx_q))
	`SFD_ASSERT_NXT(a_last_done, emit_valid && emit_ready && emit_last, rx_ready)
	`SFD_ASSERT_IMP(a_no_overlap, emit_valid || (state_q == ST_UNPACK), !rx_ready)

endmodule

FILE: hw/rtl/sbus_frame_decoder_top.sv
// Start, flags and dropped-end bytes are taken without a stall; a data byte
// stalls while the shared bit inserter writes its eight bits one per cycle.
// A good end byte puts out sixteen channel beats, one per cycle when taken at
// once; the first passes through the sequencer state and the output register,
// and no byte is accepted until the sixteenth has entered the output register.
// Reset clears the position, the accumulators, the flags and the output valid.
module sbus_frame_decoder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sfd_pkg::BYTE_W-1:0]    rx_byte,
	input  logic                          rx_valid,
	output logic                          rx_ready,
	output logic [sfd_pkg::CH_IDX_W-1:0]  channel_index,
	output logic [sfd_pkg::CH_BITS-1:0]   channel_value,
	output logic                          failsafe,
	output logic                          link_lost,
	output logic                          last_channel,
	output logic                          ch_valid,
	input  logic                          ch_ready
);
	import sfd_pkg::*;

	acc_cmd_t            acc_cmd;
	logic [CH_IDX_W-1:0] rd_ch;
	logic [CH_BITS-1:0]  rd_data;
	logic                emit_valid;
	emit_t               emit;
	logic                emit_ready;
	logic                out_valid_q;
	emit_t               out_q;

	sfd_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (acc_cmd),
		.rd_ch   (rd_ch),
		.rd_data (rd_data)
	);

	sfd_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (rx_byte),
		.rx_valid   (rx_valid),
		.rx_ready   (rx_ready),
		.acc_cmd    (acc_cmd),
		.rd_ch      (rd_ch),
		.rd_data    (rd_data),
		.emit_valid (emit_valid),
		.emit       (emit),
		.emit_ready (emit_ready)
	);

	// The output register refills in the same cycle its beat is taken.
	assign emit_ready = !out_valid_q || ch_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_ready) begin
			out_valid_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ready && emit_valid) begin
			out_q <= emit;
		end
	end

	assign ch_valid      = out_valid_q;
	assign channel_index = out_q.idx;
	assign channel_value = out_q.value;
	assign failsafe      = out_q.failsafe;
	assign link_lost     = out_q.link_lost;
	assign last_channel  = out_q.last;

endmodule
